@@ src/rmsavg_pkg.sv @@
// ----------------------------------------------------------------------------
// rmsavg_pkg
// shared widths, constants, register indexes, controller states and the
// command and status words between controller and datapath
// ----------------------------------------------------------------------------
package rmsavg_pkg;

  localparam int WINDOW_LEN_DEF = 10;

  localparam int SAMPLE_W    = 16;
  localparam int CODE_W      = 10;
  localparam int SUM_W       = 20;
  localparam int AMPS_W      = 6;
  localparam int LIMIT_W     = 13;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_MIN = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT_MAX = 1'b1;

  localparam logic [AMPS_W-1:0] AMPS_MIN_RST = 6'd7;
  localparam logic [AMPS_W-1:0] AMPS_MAX_RST = 6'd20;

  // limit scaling: code * span * 100 / 1023 by reciprocal multiply
  localparam int PROD1_W    = CODE_W + AMPS_W;
  localparam int PROD2_W    = 23;
  localparam int LIM_MULT_W = 24;
  localparam int LIM_PROD_W = PROD2_W + LIM_MULT_W;
  localparam int LIM_SHIFT  = 33;
  localparam logic [6:0] SCALE_FACTOR = 7'd100;
  localparam logic [LIM_MULT_W-1:0] LIM_MULT = 24'd8396809;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_SCALE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic update;
    logic divide;
    logic scale;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ src/rmsavg_ctrl.sv @@
// ----------------------------------------------------------------------------
// rmsavg_ctrl
// sequencer: accept, window update, average divide, limit scale, finish
// ----------------------------------------------------------------------------
module rmsavg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  rmsavg_pkg::status_t status,
  output rmsavg_pkg::cmd_t    cmd
);

  rmsavg_pkg::state_t state;
  rmsavg_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmsavg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      rmsavg_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = rmsavg_pkg::ST_UPDATE;
        end
      end
      rmsavg_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = rmsavg_pkg::ST_DIVIDE;
      end
      rmsavg_pkg::ST_DIVIDE: begin
        cmd.divide = 1'b1;
        state_next = rmsavg_pkg::ST_SCALE;
      end
      rmsavg_pkg::ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = rmsavg_pkg::ST_FINISH;
      end
      rmsavg_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = rmsavg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rmsavg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/rmsavg_datapath.sv @@
// ----------------------------------------------------------------------------
// rmsavg_datapath
// sample windows, running sums, reciprocal divides, limit scaling,
// held outputs, config registers and the output word register
// ----------------------------------------------------------------------------
module rmsavg_datapath #(
  parameter int WINDOW_LEN = rmsavg_pkg::WINDOW_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rmsavg_pkg::cmd_t                     cmd,
  output rmsavg_pkg::status_t                  status,
  input  logic [rmsavg_pkg::IN_TDATA_W-1:0]    in_word,
  input  logic                                 cfg_we,
  input  logic [rmsavg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rmsavg_pkg::AMPS_W-1:0]        cfg_data,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [rmsavg_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int SAMPLE_W   = rmsavg_pkg::SAMPLE_W;
  localparam int SUM_W      = rmsavg_pkg::SUM_W;
  localparam int LIMIT_W    = rmsavg_pkg::LIMIT_W;
  localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int DIV_SHIFT  = SUM_W + IDX_W;
  localparam int MULT_W     = SUM_W + 1;
  localparam int DIV_PROD_W = SUM_W + MULT_W;
  localparam logic [MULT_W-1:0] DIV_MULT =
    MULT_W'((2 ** DIV_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN);
  localparam logic [IDX_W:0] LAST_WRAP = (IDX_W + 1)'(WINDOW_LEN);

  logic [SAMPLE_W-1:0] v_in;
  logic [SAMPLE_W-1:0] c_in;
  logic [rmsavg_pkg::CODE_W-1:0] code_in;

  logic [SAMPLE_W-1:0] vwin [WINDOW_LEN];
  logic [SAMPLE_W-1:0] cwin [WINDOW_LEN];
  logic [SUM_W-1:0]    vsum;
  logic [SUM_W-1:0]    csum;
  logic [IDX_W-1:0]    idx;
  logic                full;
  logic                pulse;

  logic [rmsavg_pkg::AMPS_W-1:0] amps_min;
  logic [rmsavg_pkg::AMPS_W-1:0] amps_max;
  logic [rmsavg_pkg::AMPS_W-1:0] span;

  logic [rmsavg_pkg::PROD1_W-1:0]    prod1;
  logic [rmsavg_pkg::PROD2_W-1:0]    prod2;
  logic [rmsavg_pkg::LIM_PROD_W-1:0] lim_prod;
  logic [DIV_PROD_W-1:0]             vprod;
  logic [DIV_PROD_W-1:0]             cprod;

  logic [SAMPLE_W-1:0] held_avg_v;
  logic [SAMPLE_W-1:0] held_avg_i;
  logic [LIMIT_W-1:0]  held_limit;
  logic                held_over;

  logic [IDX_W:0]      idx_inc;
  logic [LIMIT_W:0]    lim_base;
  logic [LIMIT_W:0]    lim_sum;
  logic [SAMPLE_W-1:0] avg_v_new;
  logic [SAMPLE_W-1:0] avg_i_new;
  logic [LIMIT_W-1:0]  lim_new;
  logic                over_new;
  logic [SAMPLE_W-1:0] avg_v_sel;
  logic [SAMPLE_W-1:0] avg_i_sel;
  logic [LIMIT_W-1:0]  lim_sel;
  logic                over_sel;

  assign span    = (amps_max >= amps_min) ? (amps_max - amps_min) : '0;
  assign idx_inc = {1'b0, idx} + (IDX_W + 1)'(1);

  assign avg_v_new = vprod[DIV_SHIFT +: SAMPLE_W];
  assign avg_i_new = cprod[DIV_SHIFT +: SAMPLE_W];
  assign lim_base  = (LIMIT_W + 1)'(amps_min) * (LIMIT_W + 1)'(rmsavg_pkg::SCALE_FACTOR);
  assign lim_sum   = (LIMIT_W + 1)'(lim_prod[rmsavg_pkg::LIM_SHIFT +: LIMIT_W]) + lim_base;
  assign lim_new   = lim_sum[LIMIT_W-1:0];
  assign over_new  = SAMPLE_W'(lim_new) < avg_i_new;

  assign avg_v_sel = full ? avg_v_new : held_avg_v;
  assign avg_i_sel = full ? avg_i_new : held_avg_i;
  assign lim_sel   = full ? lim_new   : held_limit;
  assign over_sel  = full ? over_new  : held_over;

  assign status.out_free = !m_tvalid || m_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      amps_min <= rmsavg_pkg::AMPS_MIN_RST;
      amps_max <= rmsavg_pkg::AMPS_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmsavg_pkg::CFG_LIMIT_MIN: amps_min <= cfg_data;
        rmsavg_pkg::CFG_LIMIT_MAX: amps_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      v_in    <= in_word[SAMPLE_W-1:0];
      c_in    <= in_word[2*SAMPLE_W-1:SAMPLE_W];
      code_in <= in_word[2*SAMPLE_W +: rmsavg_pkg::CODE_W];
    end
  end

  // windows, sums, index and fill flag
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        vwin[i] <= '0;
        cwin[i] <= '0;
      end
      vsum  <= '0;
      csum  <= '0;
      idx   <= '0;
      full  <= 1'b0;
      pulse <= 1'b0;
    end else if (cmd.update) begin
      vsum      <= vsum - SUM_W'(vwin[idx]) + SUM_W'(v_in);
      csum      <= csum - SUM_W'(cwin[idx]) + SUM_W'(c_in);
      vwin[idx] <= v_in;
      cwin[idx] <= c_in;
      if (idx_inc >= LAST_WRAP) begin
        idx   <= '0;
        full  <= 1'b1;
        pulse <= !full;
      end else begin
        idx   <= idx_inc[IDX_W-1:0];
        pulse <= 1'b0;
      end
    end
  end

  // multiply steps
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      prod1 <= rmsavg_pkg::PROD1_W'(code_in) * rmsavg_pkg::PROD1_W'(span);
    end
    if (cmd.divide) begin
      vprod <= DIV_PROD_W'(vsum) * DIV_PROD_W'(DIV_MULT);
      cprod <= DIV_PROD_W'(csum) * DIV_PROD_W'(DIV_MULT);
      prod2 <= rmsavg_pkg::PROD2_W'(prod1) * rmsavg_pkg::PROD2_W'(rmsavg_pkg::SCALE_FACTOR);
    end
    if (cmd.scale) begin
      lim_prod <= rmsavg_pkg::LIM_PROD_W'(prod2)
                * rmsavg_pkg::LIM_PROD_W'(rmsavg_pkg::LIM_MULT);
    end
  end

  // held results
  always_ff @(posedge clk) begin
    if (rst) begin
      held_avg_v <= '0;
      held_avg_i <= '0;
      held_limit <= '0;
      held_over  <= 1'b0;
    end else if (cmd.finish && full) begin
      held_avg_v <= avg_v_new;
      held_avg_i <= avg_i_new;
      held_limit <= lim_new;
      held_over  <= over_new;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= rmsavg_pkg::OUT_TDATA_W'({pulse, full, over_sel, lim_sel, avg_i_sel, avg_v_sel});
    end
  end

endmodule

@@ src/rms_average_overcurrent_alarm_top.sv @@
// ----------------------------------------------------------------------------
// rms_average_overcurrent_alarm_top
// moving average of rms voltage and current with an over-current alarm
// ----------------------------------------------------------------------------
// each accepted word runs through the sequencer steps (window update, reciprocal
//   divide multiply, limit scale multiply, finish) and then the output word is
//   registered; no new input word is taken until the finish step is done
// a stalled output word holds the sequencer in its finish step
// reset (synchronous): clears windows, sums, index, fill flag, held results,
//   limits back to 7 and 20 amps; no clearing pass
module rms_average_overcurrent_alarm_top #(
  parameter int WINDOW_LEN = rmsavg_pkg::WINDOW_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // voltage_sample[15:0], current_sample[31:16], setpoint_code[41:32], zero[47:42]
  input  logic [rmsavg_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // avg_voltage[15:0], avg_current[31:16], current_limit[44:32], over_limit[45],
  // window_full[46], first_full_pulse[47]
  output logic [rmsavg_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rmsavg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rmsavg_pkg::AMPS_W-1:0]       cfg_data
);

  rmsavg_pkg::cmd_t    cmd;
  rmsavg_pkg::status_t status;

  assign cfg_ready = 1'b1;

  rmsavg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rmsavg_datapath #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_word   (s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ src/rmsavg_checker.sv @@
// ----------------------------------------------------------------------------
// rmsavg_checker
// port-level checks of the alarm block, bound to the top level
// ----------------------------------------------------------------------------
module rmsavg_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [rmsavg_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // first-full pulse only with full set
  a_pulse_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[47] |-> m_tdata[46])
    else $error("first_full_pulse without window_full");

  // results stay zero until the windows fill
  a_zero_before_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[46] |-> m_tdata[45:0] == 46'd0)
    else $error("nonzero result before window full");

  // alarm agrees with limit and average current
  a_over_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[46] |-> m_tdata[45] == ({3'b000, m_tdata[44:32]} < m_tdata[31:16]))
    else $error("over_limit disagrees with limit and average");

  // one word at a time through the sequencer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on back-to-back cycles");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

endmodule

bind rms_average_overcurrent_alarm_top rmsavg_checker u_rmsavg_checker (.*);

@@ dv/tb_rms_average_overcurrent_alarm_top.sv @@
// ----------------------------------------------------------------------------
// tb_rms_average_overcurrent_alarm_top
// The testbench drives voltage, current and setpoint words into the moving
// average alarm and checks every output word against its own model. The
// model keeps the sample windows, running sums and limit registers. The run
// has a directed fill and limit part and then random phases with idling and
// back pressure. Every limit setting is written while the block is idle.
// ----------------------------------------------------------------------------
module tb_rms_average_overcurrent_alarm_top;

  localparam int WINDOW      = rmsavg_pkg::WINDOW_LEN_DEF;
  localparam int SAMPLE_W    = rmsavg_pkg::SAMPLE_W;
  localparam int CODE_W      = rmsavg_pkg::CODE_W;
  localparam int SUM_W       = rmsavg_pkg::SUM_W;
  localparam int AMPS_W      = rmsavg_pkg::AMPS_W;
  localparam int LIMIT_W     = rmsavg_pkg::LIMIT_W;
  localparam int IN_TDATA_W  = rmsavg_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = rmsavg_pkg::OUT_TDATA_W;
  localparam int CFG_INDEX_W = rmsavg_pkg::CFG_INDEX_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 40;

  typedef struct packed {
    logic [IN_TDATA_W-2*SAMPLE_W-CODE_W-1:0] pad;
    logic [CODE_W-1:0]                       code;
    logic [SAMPLE_W-1:0]                     current;
    logic [SAMPLE_W-1:0]                     voltage;
  } reading_word_t;

  typedef struct packed {
    logic                pulse;
    logic                full;
    logic                over;
    logic [LIMIT_W-1:0]  limit;
    logic [SAMPLE_W-1:0] avg_current;
    logic [SAMPLE_W-1:0] avg_voltage;
  } average_word_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = rmsavg_pkg::CFG_LIMIT_MIN;
  logic [AMPS_W-1:0]      cfg_data  = '0;

  // averaging model state
  logic [SAMPLE_W-1:0] win_voltage [WINDOW] = '{default: '0};
  logic [SAMPLE_W-1:0] win_current [WINDOW] = '{default: '0};
  logic [SUM_W-1:0]    sum_voltage  = '0;
  logic [SUM_W-1:0]    sum_current  = '0;
  int                  slot         = 0;
  bit                  windows_full = 1'b0;
  average_word_t       held_word    = '0;
  logic [AMPS_W-1:0]   lim_min      = rmsavg_pkg::AMPS_MIN_RST;
  logic [AMPS_W-1:0]   lim_max      = rmsavg_pkg::AMPS_MAX_RST;

  average_word_t expected_words [$];

  int  send_idle_pct  = 0;
  int  rx_stall_pct   = 0;
  int  hold_off_left  = 0;
  bit  low_band       = 1'b1;
  int  cycle_count    = 0;
  int  mismatches     = 0;
  int  words_sent     = 0;
  int  words_checked  = 0;
  int  alarms_seen    = 0;
  int  pulses_seen    = 0;
  int  settings_count = 0;

  rms_average_overcurrent_alarm_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // sample window update, averages and limit scaling for one accepted word
  function automatic average_word_t advance_averages(input reading_word_t w);
    average_word_t r;
    int unsigned   span;
    int unsigned   lim;
    r = '0;
    sum_voltage = sum_voltage - win_voltage[slot] + w.voltage;
    sum_current = sum_current - win_current[slot] + w.current;
    win_voltage[slot] = w.voltage;
    win_current[slot] = w.current;
    slot = slot + 1;
    if (slot >= WINDOW) begin
      slot = 0;
      if (!windows_full) begin
        windows_full = 1'b1;
        r.pulse = 1'b1;
      end
    end
    if (windows_full) begin
      span = (lim_max >= lim_min) ? lim_max - lim_min : 0;
      lim  = w.code * span * 100 / 1023 + lim_min * 100;
      held_word.avg_voltage = sum_voltage / WINDOW;
      held_word.avg_current = sum_current / WINDOW;
      held_word.limit       = lim[LIMIT_W-1:0];
      held_word.over        = held_word.limit < held_word.avg_current;
    end
    r.avg_voltage = held_word.avg_voltage;
    r.avg_current = held_word.avg_current;
    r.limit       = held_word.limit;
    r.over        = held_word.over;
    r.full        = windows_full;
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
    if (exp_val != got_val) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $error("%s expected %0d got %0d", name, exp_val, got_val);
    end
  endtask

  task automatic check_word(input average_word_t got);
    average_word_t exp_w;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $error("output word with none expected: %h", got);
    end else begin
      exp_w = expected_words.pop_front();
      compare_field("avg_voltage", exp_w.avg_voltage, got.avg_voltage);
      compare_field("avg_current", exp_w.avg_current, got.avg_current);
      compare_field("current_limit", exp_w.limit, got.limit);
      compare_field("over_limit", exp_w.over, got.over);
      compare_field("window_full", exp_w.full, got.full);
      compare_field("first_full_pulse", exp_w.pulse, got.pulse);
      words_checked++;
      alarms_seen += exp_w.over;
      pulses_seen += exp_w.pulse;
    end
  endtask

  // handshake monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rmsavg_pkg::CFG_LIMIT_MIN) lim_min = cfg_data;
        else lim_max = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        expected_words.push_back(advance_averages(reading_word_t'(s_tdata)));
        words_sent++;
      end
      if (m_tvalid && m_tready) check_word(average_word_t'(m_tdata));
    end
  end

  // output side ready with random stalls and long hold-offs
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_word(input logic [SAMPLE_W-1:0] volt, input logic [SAMPLE_W-1:0] curr,
                           input logic [CODE_W-1:0] code);
    reading_word_t w;
    w = '0;
    w.voltage = volt;
    w.current = curr;
    w.code    = code;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= w;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random_word();
    logic [SAMPLE_W-1:0] volt;
    logic [SAMPLE_W-1:0] curr;
    logic [CODE_W-1:0]   code;
    if ($urandom_range(15) == 0) low_band = !low_band;
    case ($urandom_range(9))
      0:       volt = '0;
      1:       volt = '1;
      default: volt = SAMPLE_W'($urandom);
    endcase
    case ($urandom_range(9))
      0:       curr = low_band ? '0 : '1;
      default: curr = low_band ? SAMPLE_W'($urandom_range(7000)) : SAMPLE_W'($urandom);
    endcase
    case ($urandom_range(7))
      0:       code = '0;
      1:       code = '1;
      default: code = CODE_W'($urandom);
    endcase
    send_word(volt, curr, code);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [AMPS_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_limits(input logic [AMPS_W-1:0] lo, input logic [AMPS_W-1:0] hi);
    wait_idle();
    write_reg(rmsavg_pkg::CFG_LIMIT_MIN, lo);
    write_reg(rmsavg_pkg::CFG_LIMIT_MAX, hi);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_count++;
  endtask

  // outputs stay zero until the tenth word, which raises the pulse
  task automatic test_fill_window();
    send_word('0, '0, '0);
    send_word('1, '1, '1);
    send_word(16'h5555, 16'hAAAA, 10'h2AA);
    send_word(16'hAAAA, 16'h5555, 10'h155);
    for (int k = 0; k < 6; k++)
      send_word(SAMPLE_W'($urandom), SAMPLE_W'($urandom_range(9000)), CODE_W'($urandom));
  endtask

  task automatic test_limit_scaling();
    send_word('1, '1, '0);
    send_word('1, '1, '1);
    send_word('0, '0, 10'd512);
    send_word(16'd1, 16'd700, '0);
    send_word('0, '0, '1);
  endtask

  // max below min, both at maximum, both zero, full span
  task automatic test_register_extremes();
    write_limits(6'd50, 6'd0);
    send_word('0, '1, '1);
    send_word('1, 16'd4000, 10'd300);
    write_limits('1, '1);
    send_word(16'd100, '1, '1);
    send_word(16'd200, '0, '0);
    write_limits('0, '0);
    send_word('0, '0, '1);
    send_word('0, '0, '0);
    write_limits('0, 6'd63);
    send_word('1, 16'd3000, '1);
    send_word('0, 16'd3000, 10'd1);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input logic [AMPS_W-1:0] lo, input logic [AMPS_W-1:0] hi,
                                   input int count);
    write_limits(lo, hi);
    send_idle_pct = idle_pct;
    rx_stall_pct  = stall_pct;
    repeat (count) send_random_word();
    wait_idle();
  endtask

  // output held off while input keeps offering, so the block fills and stalls
  task automatic test_backpressure();
    write_limits(AMPS_W'($urandom_range(50)), AMPS_W'($urandom_range(50)));
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    hold_off_left = 300;
    repeat (40) send_random_word();
    wait_idle();
  endtask

  // bursts with a full drain between them
  task automatic test_paced_bursts();
    send_idle_pct = 0;
    rx_stall_pct  = 35;
    repeat (5) begin
      repeat (12) send_random_word();
      wait_idle();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_window();
    test_limit_scaling();
    test_register_extremes();
    test_random_phase(0, 0, 6'd0, 6'd50, 250);
    test_random_phase(57, 0, 6'd20, 6'd7, 250);
    test_random_phase(0, 57, AMPS_W'($urandom), AMPS_W'($urandom), 250);
    test_random_phase(35, 35, rmsavg_pkg::AMPS_MIN_RST, rmsavg_pkg::AMPS_MAX_RST, 250);
    test_backpressure();
    test_paced_bursts();
    wait_idle();
    $display("run covered %0d sample words over %0d limit settings, %0d results checked",
             words_sent, settings_count, words_checked);
    $display("over-limit alarms %0d, first-full pulses %0d, mismatches %0d",
             alarms_seen, pulses_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
